/* rtl/ucd_pkg.sv */
// Shared types and constants for the UTF-8 code point decoder.
package ucd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QLenW   = 3;
  localparam int unsigned OutDataW = 24;

  localparam logic [CpW-1:0] CpMax   = 21'h10FFFF;
  localparam logic [CpW-1:0] SurLo   = 21'h00D800;
  localparam logic [CpW-1:0] SurHi   = 21'h00DFFF;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StProc = 2'b10
  } ucd_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ucd_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic emit_hit;
    logic pend_valid;
    logic out_free;
  } ucd_status_t;

endpackage

/* rtl/ucd_ctrl.sv */
// Sequencing state machine for the UTF-8 code point decoder.
module ucd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ucd_pkg::ucd_status_t status_i,
  output ucd_pkg::ucd_cmd_t    cmd_o
);

  ucd_pkg::ucd_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ucd_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ucd_pkg::StProc;
        end
      end
      ucd_pkg::StProc: begin
        if (status_i.q_empty) begin
          if (!status_i.pend_valid || status_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = ucd_pkg::StIdle;
          end
        end else if (!status_i.emit_hit || !status_i.pend_valid || status_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = ucd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ucd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ucd_datapath.sv */
// Byte queue, held sequence, assembly and output registers of the decoder.
module ucd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ucd_pkg::ucd_cmd_t             cmd_i,
  output ucd_pkg::ucd_status_t          status_o,
  input  logic [ucd_pkg::ByteW-1:0]     in_byte_i,
  input  logic                          in_eot_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ucd_pkg::CpW-1:0]       out_cp_o,
  output logic                          out_last_o
);

  logic [ucd_pkg::ByteW-1:0] queue_q [ucd_pkg::QDepth];
  logic [ucd_pkg::ByteW-1:0] queue_d [ucd_pkg::QDepth];
  logic [ucd_pkg::ByteW-1:0] held_q  [ucd_pkg::QDepth];
  logic [ucd_pkg::ByteW-1:0] held_d  [ucd_pkg::QDepth];
  logic [ucd_pkg::QLenW-1:0] qlen_q, qlen_d;
  logic [2:0]                hc_q, hc_d;
  logic [1:0]                fn_q, fn_d;
  logic [1:0]                n_q, n_d;
  logic                      eot_q, eot_d;
  logic                      pend_valid_q, pend_valid_d;
  logic [ucd_pkg::CpW-1:0]   pend_cp_q, pend_cp_d;
  logic                      out_valid_q, out_valid_d;
  logic [ucd_pkg::CpW-1:0]   out_cp_q, out_cp_d;
  logic                      out_last_q, out_last_d;

  // result of feeding the front byte
  logic [ucd_pkg::ByteW-1:0] b;
  logic [ucd_pkg::ByteW-1:0] pop  [ucd_pkg::QDepth];
  logic [ucd_pkg::ByteW-1:0] hv   [ucd_pkg::QDepth];
  logic [ucd_pkg::ByteW-1:0] f_q  [ucd_pkg::QDepth];
  logic [ucd_pkg::ByteW-1:0] f_held [ucd_pkg::QDepth];
  logic [ucd_pkg::QLenW-1:0] f_qlen, qrest, qsum;
  logic [2:0]                f_hc, hc_inc;
  logic [1:0]                f_fn, hidx, pidx;
  logic                      f_emit, ok, in_range, emit_hit;
  logic [ucd_pkg::CpW-1:0]   f_cp, cp_asm;

  always_comb begin
    b      = queue_q[0];
    hv     = held_q;
    hv[hc_q[1:0]] = b;
    for (int i = 0; i < ucd_pkg::QDepth - 1; i++) begin
      pop[i] = queue_q[i+1];
    end
    pop[ucd_pkg::QDepth-1] = '0;
    hc_inc = hc_q + 3'd1;
    qrest  = qlen_q - 3'd1;
    qsum   = qrest + {1'b0, fn_q};

    ok = 1'b1;
    unique case (fn_q)
      2'd1: begin
        cp_asm = {10'b0, hv[0][4:0], hv[1][5:0]};
        ok     = (hv[1][7:6] == 2'b10);
      end
      2'd2: begin
        cp_asm = {5'b0, hv[0][3:0], hv[1][5:0], hv[2][5:0]};
        ok     = (hv[1][7:6] == 2'b10) && (hv[2][7:6] == 2'b10);
      end
      2'd3: begin
        cp_asm = {hv[0][2:0], hv[1][5:0], hv[2][5:0], hv[3][5:0]};
        ok     = (hv[1][7:6] == 2'b10) && (hv[2][7:6] == 2'b10) &&
                 (hv[3][7:6] == 2'b10);
      end
      default: cp_asm = {18'b0, hv[0][2:0]};
    endcase
    in_range = (cp_asm <= ucd_pkg::CpMax) &&
               !((cp_asm >= ucd_pkg::SurLo) && (cp_asm <= ucd_pkg::SurHi));

    f_emit = 1'b0;
    f_cp   = '0;
    f_held = held_q;
    f_hc   = hc_q;
    f_fn   = fn_q;
    f_q    = pop;
    f_qlen = qrest;
    hidx   = '0;
    pidx   = '0;
    if (hc_q == 3'd0) begin
      if (!b[7]) begin
        f_emit = 1'b1;
        f_cp   = {13'b0, b};
      end else if (b[7:5] == 3'b110) begin
        f_held[0] = b;
        f_hc      = 3'd1;
        f_fn      = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        f_held[0] = b;
        f_hc      = 3'd1;
        f_fn      = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        f_held[0] = b;
        f_hc      = 3'd1;
        f_fn      = 2'd3;
      end
    end else if (hc_q > 3'd3) begin
      f_hc = 3'd0;
      f_fn = 2'd0;
    end else begin
      f_held = hv;
      if (hc_inc < ({1'b0, fn_q} + 3'd1)) begin
        f_hc = hc_inc;
      end else begin
        f_hc = 3'd0;
        f_fn = 2'd0;
        if (ok) begin
          f_emit = in_range;
          f_cp   = cp_asm;
        end else if (qsum <= 3'd4) begin
          // bad follower: held followers go back to the queue front
          for (int i = 0; i < ucd_pkg::QDepth; i++) begin
            hidx = 2'(i) + 2'd1;
            pidx = 2'(i) - fn_q;
            if (2'(i) < fn_q) f_q[i] = hv[hidx];
            else              f_q[i] = pop[pidx];
          end
          f_qlen = qsum;
        end
      end
    end
    emit_hit = f_emit && (n_q != 2'd3);
  end

  assign status_o.q_empty    = (qlen_q == '0);
  assign status_o.emit_hit   = emit_hit;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    queue_d      = queue_q;
    qlen_d       = qlen_q;
    held_d       = held_q;
    hc_d         = hc_q;
    fn_d         = fn_q;
    n_d          = n_q;
    eot_d        = eot_q;
    pend_valid_d = pend_valid_q;
    pend_cp_d    = pend_cp_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_cp_d     = out_cp_q;
    out_last_d   = out_last_q;
    if (cmd_i.load) begin
      queue_d[0] = in_byte_i;
      qlen_d     = 3'd1;
      eot_d      = in_eot_i;
      n_d        = 2'd0;
    end
    if (cmd_i.step) begin
      queue_d = f_q;
      qlen_d  = f_qlen;
      held_d  = f_held;
      hc_d    = f_hc;
      fn_d    = f_fn;
      if (emit_hit) begin
        n_d          = n_q + 2'd1;
        pend_valid_d = 1'b1;
        pend_cp_d    = f_cp;
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_cp_d    = pend_cp_q;
          out_last_d  = 1'b0;
        end
      end
    end
    if (cmd_i.finish) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_cp_d     = pend_cp_q;
        out_last_d   = 1'b1;
        pend_valid_d = 1'b0;
      end
      if (eot_q) begin
        hc_d = 3'd0;
        fn_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q       <= '0;
      hc_q         <= '0;
      fn_q         <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      qlen_q       <= qlen_d;
      hc_q         <= hc_d;
      fn_q         <= fn_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    queue_q   <= queue_d;
    held_q    <= held_d;
    eot_q     <= eot_d;
    pend_cp_q <= pend_cp_d;
    out_cp_q  <= out_cp_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_cp_o    = out_cp_q;
  assign out_last_o  = out_last_q;

  a_qlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qlen_q <= 3'd4) else $error("replay queue overfilled");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= 3'd3) else $error("held count beyond a full sequence");

  a_held_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hc_q == 3'd0) == (fn_q == 2'd0)) else $error("held count and follower need disagree");

  a_step_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (qlen_q != '0)) else $error("step issued on empty queue");

endmodule

/* rtl/utf8_codepoint_decoder.sv */
// Top level of the streaming UTF-8 to code point decoder.
// Input channel s_axis: one text byte per transfer, tlast marks the final
// byte of a text. Output channel m_axis: one code point per transfer, tlast
// marks the last code point produced by one input byte (bytes that complete
// nothing produce no transfer).
// One input byte occupies the block from its acceptance in idle through the
// bytes worked through its replay queue (normally only the byte itself; bad
// followers send held bytes back) to a finish step that returns to idle.
// The queue works one byte per cycle through the feed logic, unless a found
// code point must wait for a stalled output register. Each code point waits
// in a pending register and moves to the output register when the next one
// is found or when the item ends.
// A stalled receiver holds the output register; the block then
// waits before it can produce a second result, and takes no new byte
// until the current one is fully delivered into the output register.
// Reset returns to idle with no sequence held and no output pending.
module utf8_codepoint_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ucd_pkg::ByteW-1:0]        s_axis_tdata_i,   // [7:0] text_byte
  input  logic                             s_axis_tlast_i,   // end_of_text
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [ucd_pkg::OutDataW-1:0]     m_axis_tdata_o,   // [20:0] code_point, [23:21] zero
  output logic                             m_axis_tlast_o    // run_end
);

  ucd_pkg::ucd_cmd_t       cmd;
  ucd_pkg::ucd_status_t    status;
  logic [ucd_pkg::CpW-1:0] out_cp;

  ucd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ucd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_byte_i   (s_axis_tdata_i),
    .in_eot_i    (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_cp_o    (out_cp),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(ucd_pkg::OutDataW - ucd_pkg::CpW){1'b0}}, out_cp};

endmodule
